// ===== src/assert_macros.svh =====
// assertion macros used by ir_grid_scan_locator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IGSL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IGSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IGSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define IGSL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/igsl_pkg.sv =====
// types and constants of the infrared grid scan locator
package igsl_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned PULSE_W   = 5;
  localparam int unsigned COORD_W   = 4;
  localparam int unsigned LOG_CNT_W = 7;

  localparam logic [SAMPLE_W-1:0] THRESH_RESET  = 12'd3723;
  localparam logic [SLOT_W-1:0]   PULSE_STEP_A  = 5'd7;
  localparam logic [SLOT_W-1:0]   PULSE_STEP_B  = 5'd14;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot_index;
    logic                 blocked;
    logic [SLOT_W-1:0]    next_slot;
    logic [PULSE_W-1:0]   next_pulses;
    logic                 frame_end;
    logic                 point_valid;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic [LOG_CNT_W-1:0] log_count;
    logic                 log_cleared;
  } result_t;

endpackage

// ===== src/igsl_in_if.sv =====
// sample channel: valid, ready and one converter sample per beat
interface igsl_in_if;
  logic               valid;
  logic               ready;
  igsl_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/igsl_out_if.sv =====
// result channel: valid, ready and one scan result per beat
interface igsl_out_if;
  logic               valid;
  logic               ready;
  igsl_pkg::result_t  res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

// ===== src/ir_grid_scan_locator.sv =====
// ir_grid_scan_locator: top level of the infrared grid scan locator
//
// in_if carries one 12-bit converter sample per beat, one beat per led slot.
// slots 0 to SLOTS_PER_AXIS-1 are the vertical beams, the next SLOTS_PER_AXIS
// slots the horizontal beams. each input beat gives exactly one result beat on
// out_if: the slot, whether its beam was blocked, the next slot and its shift
// clock count, and at the last slot of a frame the lowest blocked x and y and
// the point log count.
// cfg_we/cfg_wdata write the block threshold; write it only while idle.
// the result is registered on the edge that accepts the sample. throughput is
// one beat per cycle while the receiver takes results; the result register is the only
// stage, so in_if.ready stays high while out_if.ready is high or the result
// register is empty.
// when the receiver stalls with a result waiting, in_if.ready drops until the
// result is taken.
// reset (rst_n low, synchronous) empties the result register, restarts at
// slot 0, clears the hit bits and log count and loads the threshold with 3723.
`include "assert_macros.svh"

module ir_grid_scan_locator #(
  parameter int SLOTS_PER_AXIS = 10,
  parameter int LOG_DEPTH      = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  igsl_in_if.sink                       in_if,
  igsl_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [igsl_pkg::SAMPLE_W-1:0] cfg_wdata
);

  localparam int TOTAL_SLOTS = 2 * SLOTS_PER_AXIS;
  localparam int CNT_W       = (LOG_DEPTH > 2) ? $clog2(LOG_DEPTH) : 1;
  localparam logic [igsl_pkg::SLOT_W-1:0] LAST_SLOT = igsl_pkg::SLOT_W'(TOTAL_SLOTS - 1);
  localparam logic [CNT_W-1:0]            CNT_LAST  = CNT_W'(LOG_DEPTH - 1);

  logic [igsl_pkg::SAMPLE_W-1:0] thresh_r;
  logic [igsl_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOTS_PER_AXIS-1:0]     vhits_r, vhits_nxt, vhits_upd;
  logic [SLOTS_PER_AXIS-1:0]     hhits_r, hhits_nxt, hhits_upd;
  logic [CNT_W-1:0]              count_r, count_nxt, count_base;
  logic                          out_valid_r;
  igsl_pkg::result_t             res_r, res_nxt;

  logic                           in_ready;
  logic                           accept;
  logic                           blocked;
  logic                           fend;
  logic                           clr;
  logic                           pt_valid;
  logic                           fx, fy;
  logic [igsl_pkg::COORD_W-1:0]   xi, yi;
  logic [igsl_pkg::PULSE_W-1:0]   pulses;
  logic [31:0]                    cnt_ext;

  assign in_ready     = !out_valid_r || out_if.ready;
  assign in_if.ready  = in_ready;
  assign accept       = in_if.valid && in_ready;
  assign out_if.valid = out_valid_r;
  assign out_if.res   = res_r;

  assign blocked = in_if.sample < thresh_r;
  assign fend    = slot_r == LAST_SLOT;

  always_comb begin
    for (int i = 0; i < SLOTS_PER_AXIS; i++) begin
      vhits_upd[i] = (slot_r == igsl_pkg::SLOT_W'(i)) ? blocked : vhits_r[i];
      hhits_upd[i] = (slot_r == igsl_pkg::SLOT_W'(i + SLOTS_PER_AXIS)) ? blocked : hhits_r[i];
    end
  end

  // lowest set bit of each axis
  always_comb begin
    xi = '0;
    yi = '0;
    for (int i = SLOTS_PER_AXIS - 1; i >= 0; i--) begin
      if (hhits_upd[i]) begin
        xi = igsl_pkg::COORD_W'(i);
      end
      if (vhits_upd[i]) begin
        yi = igsl_pkg::COORD_W'(i);
      end
    end
  end

  assign fx = |hhits_upd;
  assign fy = |vhits_upd;

  assign slot_nxt = fend ? '0 : slot_r + igsl_pkg::SLOT_W'(1);

  assign pulses = slot_nxt + igsl_pkg::PULSE_W'(1)
                + igsl_pkg::PULSE_W'(slot_nxt >= igsl_pkg::PULSE_STEP_A)
                + igsl_pkg::PULSE_W'(slot_nxt >= igsl_pkg::PULSE_STEP_B);

  assign clr        = fend && (count_r >= CNT_LAST);
  assign count_base = clr ? '0 : count_r;
  assign pt_valid   = fend && fx && fy;
  assign count_nxt  = pt_valid ? count_base + CNT_W'(1) : count_base;
  assign cnt_ext    = 32'(count_nxt);

  assign vhits_nxt = fend ? '0 : vhits_upd;
  assign hhits_nxt = fend ? '0 : hhits_upd;

  always_comb begin
    res_nxt             = '0;
    res_nxt.slot_index  = slot_r;
    res_nxt.blocked     = blocked;
    res_nxt.next_slot   = slot_nxt;
    res_nxt.next_pulses = pulses;
    res_nxt.frame_end   = fend;
    res_nxt.point_valid = pt_valid;
    res_nxt.point_x     = pt_valid ? xi : '0;
    res_nxt.point_y     = pt_valid ? yi : '0;
    res_nxt.log_count   = cnt_ext[igsl_pkg::LOG_CNT_W-1:0];
    res_nxt.log_cleared = clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= igsl_pkg::THRESH_RESET;
      slot_r      <= '0;
      vhits_r     <= '0;
      hhits_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (accept) begin
        slot_r      <= slot_nxt;
        vhits_r     <= vhits_nxt;
        hhits_r     <= hhits_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  `IGSL_ASSERT(a_frame_wraps, clk, rst_n, (accept && slot_r == LAST_SLOT) |=> (slot_r == '0), "slot did not wrap at frame end")
  `IGSL_ASSERT(a_hits_cleared, clk, rst_n, (accept && fend) |=> (vhits_r == '0 && hhits_r == '0), "hit bits kept across frame end")
  `IGSL_ASSERT(a_point_at_end, clk, rst_n, (out_valid_r && (res_r.point_valid || res_r.log_cleared)) |-> res_r.frame_end, "point or log clear outside frame end")
  `IGSL_ASSERT_ALWAYS(a_slot_range, clk, !rst_n || slot_r <= LAST_SLOT, "slot beyond last slot")

endmodule

// ===== tb/tb_ir_grid_scan_locator.sv =====
// testbench for ir_grid_scan_locator: directed frame table, then random frames checked by a predictor
module tb_ir_grid_scan_locator;

  localparam int unsigned AXIS_SLOTS = 10;
  localparam int unsigned FRAME_SLOTS = 2 * AXIS_SLOTS;
  localparam int unsigned POINT_LOG_DEPTH = 128;
  localparam int unsigned TABLE_ROWS = 23;

  typedef struct {
    igsl_pkg::sample_t sample;
    bit                typed;
    igsl_pkg::result_t res;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [igsl_pkg::SAMPLE_W-1:0] cfg_wdata;

  igsl_in_if  in_if ();
  igsl_out_if out_if ();

  ir_grid_scan_locator #(
    .SLOTS_PER_AXIS(AXIS_SLOTS),
    .LOG_DEPTH(POINT_LOG_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  igsl_pkg::sample_t     threshold;
  int unsigned           scan_slot;
  logic [AXIS_SLOTS-1:0] vert_hits;
  logic [AXIS_SLOTS-1:0] horiz_hits;
  int unsigned           log_fill;
  int unsigned           log_wraps;
  igsl_pkg::result_t     scan_results_due[$];
  igsl_pkg::result_t     due;
  table_row_t            scan_table[TABLE_ROWS];
  int unsigned           items_sent;
  int unsigned           stall_left = 0;
  bit                    steady_run;
  bit                    failed = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("** ir_grid_scan_locator: FAILED **");
    $finish;
  end

  function automatic int lowest_hit(logic [AXIS_SLOTS-1:0] hits);
    for (int i = 0; i < AXIS_SLOTS; i++) begin
      if (hits[i]) return i;
    end
    return -1;
  endfunction

  function automatic igsl_pkg::result_t predict_scan(igsl_pkg::sample_t s);
    igsl_pkg::result_t r;
    int unsigned slot_now;
    int unsigned nxt;
    int unsigned pulses;
    int xi;
    int yi;
    r = '0;
    slot_now = (scan_slot >= FRAME_SLOTS) ? 0 : scan_slot;
    r.slot_index = slot_now[igsl_pkg::SLOT_W-1:0];
    r.blocked = (s < threshold);
    if (slot_now < AXIS_SLOTS) vert_hits[slot_now] = r.blocked;
    else horiz_hits[slot_now-AXIS_SLOTS] = r.blocked;
    nxt = slot_now + 1;
    if (nxt >= FRAME_SLOTS) begin
      nxt = 0;
      r.frame_end = 1'b1;
      if (log_fill >= POINT_LOG_DEPTH - 1) begin
        log_fill = 0;
        r.log_cleared = 1'b1;
        log_wraps++;
      end
      xi = lowest_hit(horiz_hits);
      yi = lowest_hit(vert_hits);
      if (xi >= 0 && yi >= 0) begin
        log_fill++;
        r.point_valid = 1'b1;
        r.point_x = xi[igsl_pkg::COORD_W-1:0];
        r.point_y = yi[igsl_pkg::COORD_W-1:0];
      end
      vert_hits = '0;
      horiz_hits = '0;
    end
    scan_slot = nxt;
    pulses = nxt + 1;
    if (nxt >= igsl_pkg::PULSE_STEP_A) pulses++;
    if (nxt >= igsl_pkg::PULSE_STEP_B) pulses++;
    r.next_slot = nxt[igsl_pkg::SLOT_W-1:0];
    r.next_pulses = pulses[igsl_pkg::PULSE_W-1:0];
    r.log_count = log_fill[igsl_pkg::LOG_CNT_W-1:0];
    return r;
  endfunction

  function automatic igsl_pkg::result_t scan_res(int unsigned slot, int unsigned blk,
                                                 int unsigned nxt, int unsigned pulses,
                                                 int unsigned fend, int unsigned pv,
                                                 int unsigned px, int unsigned py,
                                                 int unsigned cnt, int unsigned clr);
    igsl_pkg::result_t r;
    r.slot_index = slot[igsl_pkg::SLOT_W-1:0];
    r.blocked = blk[0];
    r.next_slot = nxt[igsl_pkg::SLOT_W-1:0];
    r.next_pulses = pulses[igsl_pkg::PULSE_W-1:0];
    r.frame_end = fend[0];
    r.point_valid = pv[0];
    r.point_x = px[igsl_pkg::COORD_W-1:0];
    r.point_y = py[igsl_pkg::COORD_W-1:0];
    r.log_count = cnt[igsl_pkg::LOG_CNT_W-1:0];
    r.log_cleared = clr[0];
    return r;
  endfunction

  function automatic int unsigned idle_len(bit nonzero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 65 && !nonzero) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (scan_results_due.size() == 0) begin
        $error("result beat with no expected result pending");
        failed = 1'b1;
      end else begin
        due = scan_results_due.pop_front();
        cmp_field("slot_index", due.slot_index, out_if.res.slot_index);
        cmp_field("blocked", due.blocked, out_if.res.blocked);
        cmp_field("next_slot", due.next_slot, out_if.res.next_slot);
        cmp_field("next_pulses", due.next_pulses, out_if.res.next_pulses);
        cmp_field("frame_end", due.frame_end, out_if.res.frame_end);
        cmp_field("point_valid", due.point_valid, out_if.res.point_valid);
        cmp_field("point_x", due.point_x, out_if.res.point_x);
        cmp_field("point_y", due.point_y, out_if.res.point_y);
        cmp_field("log_count", due.log_count, out_if.res.log_count);
        cmp_field("log_cleared", due.log_cleared, out_if.res.log_cleared);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!steady_run && $urandom_range(0, 3) == 0) stall_left = idle_len(1'b1);
    end
  end

  task automatic send_sample(input igsl_pkg::sample_t s, input bit typed,
                             input igsl_pkg::result_t typed_res);
    igsl_pkg::result_t r;
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    r = predict_scan(s);
    scan_results_due.push_back(typed ? typed_res : r);
    items_sent++;
    gap = idle_len(1'b0);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_threshold(input igsl_pkg::sample_t v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic igsl_pkg::sample_t beam_sample(bit want_blocked);
    bit edge_pick;
    edge_pick = ($urandom_range(0, 3) == 0);
    if (want_blocked && threshold != 0)
      return edge_pick ? igsl_pkg::sample_t'(threshold - 1)
                       : igsl_pkg::sample_t'($urandom_range(0, threshold - 1));
    return edge_pick ? threshold : igsl_pkg::sample_t'($urandom_range(threshold, 4095));
  endfunction

  task automatic run_frames(input int unsigned frames);
    bit noisy;
    bit want_point;
    bit want_blocked;
    int unsigned xb;
    int unsigned yb;
    int unsigned k;
    igsl_pkg::sample_t s;
    repeat (frames) begin
      noisy = ($urandom_range(0, 4) == 0);
      want_point = ($urandom_range(0, 7) != 0);
      xb = $urandom_range(0, AXIS_SLOTS - 1);
      yb = $urandom_range(0, AXIS_SLOTS - 1);
      repeat (FRAME_SLOTS) begin
        k = scan_slot;
        want_blocked = (want_point && (k == yb || k == AXIS_SLOTS + xb)) ||
                       ($urandom_range(0, 7) == 0);
        s = noisy ? igsl_pkg::sample_t'($urandom_range(0, 4095)) : beam_sample(want_blocked);
        send_sample(s, 1'b0, '0);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    threshold = igsl_pkg::THRESH_RESET;
    scan_slot = 0;
    vert_hits = '0;
    horiz_hits = '0;
    log_fill = 0;
    log_wraps = 0;
    items_sent = 0;
    steady_run = 1'b0;

    for (int i = 0; i < TABLE_ROWS; i++) scan_table[i] = '{12'hFFF, 1'b0, '0};
    scan_table[0]  = '{12'd0,    1'b1, scan_res(0, 1, 1, 2, 0, 0, 0, 0, 0, 0)};
    scan_table[1]  = '{12'd4095, 1'b1, scan_res(1, 0, 2, 3, 0, 0, 0, 0, 0, 0)};
    scan_table[2]  = '{12'd3722, 1'b1, scan_res(2, 1, 3, 4, 0, 0, 0, 0, 0, 0)};
    scan_table[3]  = '{12'd3723, 1'b1, scan_res(3, 0, 4, 5, 0, 0, 0, 0, 0, 0)};
    scan_table[6]  = '{12'd4095, 1'b1, scan_res(6, 0, 7, 9, 0, 0, 0, 0, 0, 0)};
    scan_table[13] = '{12'd4095, 1'b1, scan_res(13, 0, 14, 17, 0, 0, 0, 0, 0, 0)};
    scan_table[18] = '{12'd4095, 1'b1, scan_res(18, 0, 19, 22, 0, 0, 0, 0, 0, 0)};
    scan_table[19] = '{12'd0,    1'b1, scan_res(19, 1, 0, 1, 1, 1, 9, 0, 1, 0)};
    scan_table[20] = '{12'h800,  1'b0, '0};
    scan_table[21] = '{12'h7FF,  1'b0, '0};
    scan_table[22] = '{12'h555,  1'b0, '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (scan_table[i]) send_sample(scan_table[i].sample, scan_table[i].typed, scan_table[i].res);

    phase = 0;
    while (!(items_sent >= 2000 && log_wraps != 0) && items_sent < 5000) begin
      case (phase)
        0: ;
        1: set_threshold(12'd0);
        2: set_threshold(12'd4095);
        3: set_threshold(12'd1);
        4: set_threshold(igsl_pkg::THRESH_RESET);
        default: set_threshold(igsl_pkg::sample_t'($urandom_range(0, 4095)));
      endcase
      steady_run = (phase % 4 == 3);
      run_frames((phase == 1) ? 2 : $urandom_range(3, 12));
      repeat ($urandom_range(0, FRAME_SLOTS - 1))
        send_sample(igsl_pkg::sample_t'($urandom), 1'b0, '0);
      phase++;
    end
    steady_run = 1'b0;

    drain_results();
    if (failed) begin
      $display("** ir_grid_scan_locator: FAILED **");
    end else begin
      $display("** ir_grid_scan_locator: PASSED **");
    end
    $finish;
  end

endmodule
